// File: rtl/gpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_pkg
// Shared constants for the binary field multiply / exponentiate unit.
// ----------------------------------------------------------------------------
package gpm_pkg;

  // Multiplier bits consumed per pipeline stage
  localparam int unsigned MUL_STEP = 8;

  // Register file
  localparam int unsigned APB_AW   = 4;
  localparam int unsigned APB_DW   = 64;
  localparam logic        IDX_MODULUS = 1'b0;
  localparam logic [63:0] MODULUS_RST = 64'h8000_0000_0000_0003;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_MUL = 2'd1,
    MODE_POW = 2'd2,
    MODE_NOP = 2'd3
  } mode_e;

endpackage
`default_nettype wire

// File: rtl/gf2_poly_mul_exp_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_poly_mul_exp_top
// Binary polynomial field add / multiply / power unit, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled and returns one
// result word per input word, in order. Every word, whatever its mode,
// travels the same pipeline. That pipeline is made of the multiplier chain:
// one multiplier for the plain product, then a square and a multiply for
// each exponent bit, each multiplier retiring 8 operand bits per register
// stage. The whole pipeline advances together whenever the output register
// is empty or being taken, so a stall at the output freezes every stage and
// nothing is lost or repeated.
// The modulus register (byte address 0 on the APB port) must only be written
// while the pipeline is empty; only its low POLY_BITS bits are used.
// ----------------------------------------------------------------------------
module gf2_poly_mul_exp_top #(
  parameter int unsigned POLY_BITS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [63:0] operand_a_i,
  input  wire logic [63:0] operand_b_i,
  // result words
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_o,
  // configuration
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [gpm_pkg::APB_AW-1:0]     paddr,
  input  wire logic [gpm_pkg::APB_DW-1:0]     pwdata,
  output logic      [gpm_pkg::APB_DW-1:0]     prdata,
  output logic                                pready
);
  import gpm_pkg::*;

  localparam int unsigned P  = POLY_BITS;
  localparam int unsigned RW = 3 * P + 2;

  // ---------------- configuration ----------------
  logic [63:0] modulus_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == IDX_MODULUS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RST;
    end else if (cfg_wr) begin
      modulus_q <= pwdata;
    end
  end

  assign prdata = (paddr[APB_AW-1] == IDX_MODULUS) ? modulus_q : '0;

  logic [P-1:0] modulus;
  assign modulus = modulus_q[P-1:0];

  // ---------------- flow control ----------------
  // Single global advance: every stage moves when the output slot frees.
  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // ---------------- front multiplier: a * b ----------------
  logic [P-1:0]   op_a, op_b;
  logic           m0_vld;
  logic [P-1:0]   m0_prod;
  logic [2*P+1:0] m0_side;   // {mode, a, b}

  assign op_a = operand_a_i[P-1:0];
  assign op_b = operand_b_i[P-1:0];

  gpm_mul #(.P(P), .SW(2 * P + 2)) u_mul0 (
    .clk_i, .rst_ni,
    .en_i      (en),
    .vld_i     (in_valid_i),
    .x_i       (op_a),
    .y_i       (op_b),
    .side_i    ({mode_i, op_a, op_b}),
    .modulus_i (modulus),
    .vld_o     (m0_vld),
    .prod_o    (m0_prod),
    .side_o    (m0_side)
  );

  // Non-power result is settled here and rides along in the record.
  logic [1:0]   m0_mode;
  logic [P-1:0] m0_a, m0_b, m0_res;

  assign m0_mode = m0_side[2*P+1:2*P];
  assign m0_a    = m0_side[2*P-1:P];
  assign m0_b    = m0_side[P-1:0];

  always_comb begin
    case (m0_mode)
      MODE_ADD: m0_res = m0_a ^ m0_b;
      MODE_MUL: m0_res = m0_prod;
      default:  m0_res = '0;
    endcase
  end

  // ---------------- square-and-multiply chain, MSB first ----------------
  logic          pw_vld [P+1];
  logic [P-1:0]  pw_acc [P+1];
  logic [RW-1:0] pw_rec [P+1];

  assign pw_vld[0] = m0_vld;
  assign pw_acc[0] = {{(P-1){1'b0}}, 1'b1};
  assign pw_rec[0] = {m0_mode, m0_a, m0_b, m0_res};

  for (genvar j = 0; j < P; j++) begin : g_pow
    gpm_pow_step #(.P(P), .BIT(P - 1 - j)) u_step (
      .clk_i, .rst_ni,
      .en_i      (en),
      .vld_i     (pw_vld[j]),
      .acc_i     (pw_acc[j]),
      .rec_i     (pw_rec[j]),
      .modulus_i (modulus),
      .vld_o     (pw_vld[j+1]),
      .acc_o     (pw_acc[j+1]),
      .rec_o     (pw_rec[j+1])
    );
  end

  // ---------------- result ----------------
  logic [1:0]   out_mode;
  logic [P-1:0] out_word;

  assign out_mode    = pw_rec[P][RW-1:RW-2];
  assign out_valid_o = pw_vld[P];
  assign out_word    = (out_mode == MODE_POW) ? pw_acc[P] : pw_rec[P][P-1:0];
  assign result_o    = 64'(out_word);

  // ---------------- assertions ----------------
  a_mod_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> modulus_q == $past(pwdata))
    else $error("modulus write lost");

  a_nop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_mode == MODE_NOP) |-> result_o == 64'd0)
    else $error("unused mode gave nonzero result");

  a_width : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_o >> P) == 64'd0)
    else $error("result wider than field");

endmodule
`default_nettype wire

// File: rtl/gpm_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_mul
// Pipelined field multiplier, MSB-first shift-and-add, MUL_STEP bits a stage.
// ----------------------------------------------------------------------------
module gpm_mul #(
  parameter int unsigned P  = 64,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          vld_i,
  input  wire logic [P-1:0]  x_i,
  input  wire logic [P-1:0]  y_i,
  input  wire logic [SW-1:0] side_i,
  input  wire logic [P-1:0]  modulus_i,
  output logic               vld_o,
  output logic [P-1:0]       prod_o,
  output logic [SW-1:0]      side_o
);
  import gpm_pkg::*;

  localparam int unsigned NST = (P + MUL_STEP - 1) / MUL_STEP;

  logic [NST-1:0] vld_q;
  logic [P-1:0]   acc_q  [NST];
  logic [P-1:0]   x_q    [NST];
  logic [P-1:0]   y_q    [NST];
  logic [SW-1:0]  side_q [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stg
    logic          vld_in;
    logic [P-1:0]  acc_in, x_in, y_in, acc_d;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_first
      assign vld_in  = vld_i;
      assign acc_in  = '0;
      assign x_in    = x_i;
      assign y_in    = y_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign x_in    = x_q[s-1];
      assign y_in    = y_q[s-1];
      assign side_in = side_q[s-1];
    end

    // up to MUL_STEP Horner steps: acc = (acc << 1, reduced) ^ (y bit ? x : 0)
    always_comb begin
      logic [P-1:0] t;
      int           idx;
      t = acc_in;
      for (int k = 0; k < int'(MUL_STEP); k++) begin
        idx = int'(P) - 1 - int'(s * MUL_STEP) - k;
        if (idx >= 0) begin
          t = {t[P-2:0], 1'b0};
          if (t[P-1]) begin
            t = t ^ modulus_i;
          end
          if (y_in[idx[$clog2(P)-1:0]]) begin
            t = t ^ x_in;
          end
        end
      end
      acc_d = t;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[s]  <= acc_d;
        x_q[s]    <= x_in;
        y_q[s]    <= y_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign vld_o  = vld_q[NST-1];
  assign prod_o = acc_q[NST-1];
  assign side_o = side_q[NST-1];

endmodule
`default_nettype wire

// File: rtl/gpm_pow_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpm_pow_step
// One exponent bit of square-and-multiply: square, then multiply by the base
// and keep it when the exponent bit is set.
// ----------------------------------------------------------------------------
module gpm_pow_step #(
  parameter int unsigned P   = 64,
  parameter int unsigned BIT = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            vld_i,
  input  wire logic [P-1:0]    acc_i,
  input  wire logic [3*P+1:0]  rec_i,   // {mode, base, exponent, side result}
  input  wire logic [P-1:0]    modulus_i,
  output logic                 vld_o,
  output logic [P-1:0]         acc_o,
  output logic [3*P+1:0]       rec_o
);
  import gpm_pkg::*;

  localparam int unsigned RW = 3 * P + 2;

  logic          sq_vld, mu_vld;
  logic [P-1:0]  sq, mu;
  logic [RW-1:0] sq_rec;
  logic [RW+P-1:0] mu_side;

  gpm_mul #(.P(P), .SW(RW)) u_sqr (
    .clk_i, .rst_ni, .en_i,
    .vld_i     (vld_i),
    .x_i       (acc_i),
    .y_i       (acc_i),
    .side_i    (rec_i),
    .modulus_i (modulus_i),
    .vld_o     (sq_vld),
    .prod_o    (sq),
    .side_o    (sq_rec)
  );

  gpm_mul #(.P(P), .SW(RW + P)) u_mul (
    .clk_i, .rst_ni, .en_i,
    .vld_i     (sq_vld),
    .x_i       (sq),
    .y_i       (sq_rec[3*P-1:2*P]),
    .side_i    ({sq_rec, sq}),
    .modulus_i (modulus_i),
    .vld_o     (mu_vld),
    .prod_o    (mu),
    .side_o    (mu_side)
  );

  // exponent field sits above the squared word and the side result
  assign vld_o = mu_vld;
  assign rec_o = mu_side[RW+P-1:P];
  assign acc_o = mu_side[2*P + BIT] ? mu : mu_side[P-1:0];

endmodule
`default_nettype wire
